/* rtl/multi_servo_pwm_ramp_assert.svh */
// Assertion macros shared by the servo pulse generator RTL.
`ifndef MULTI_SERVO_PWM_RAMP_ASSERT_SVH
`define MULTI_SERVO_PWM_RAMP_ASSERT_SVH

// The property must hold in the same cycle as the condition.
`define MSR_ASSERT_IMPLY(label, clk, rstn, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |-> (prop)) \
        else $error("servo pwm assertion failed");

// The property must hold in the cycle after the condition.
`define MSR_ASSERT_NEXT(label, clk, rstn, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |=> (prop)) \
        else $error("servo pwm assertion failed");

`endif

/* rtl/msr_pkg.sv */
// Shared types, constants and helpers of the servo pulse generator.
package msr_pkg;

    localparam logic [11:0] PULSE_MIN_RESET   = 12'd500;
    localparam logic [11:0] PULSE_MAX_RESET   = 12'd2500;
    localparam logic [12:0] SLOT_LENGTH_RESET = 13'd5000;
    localparam logic [7:0]  RAMP_STEP_RESET   = 8'd20;
    localparam logic [13:0] RAMP_MAX_RESET    = 14'd10000;
    localparam logic [11:0] WIDTH_RESET_US    = 12'd1500;

    localparam logic [2:0] CFG_PULSE_MIN   = 3'd0;
    localparam logic [2:0] CFG_PULSE_MAX   = 3'd1;
    localparam logic [2:0] CFG_SLOT_LENGTH = 3'd2;
    localparam logic [2:0] CFG_RAMP_STEP   = 3'd3;
    localparam logic [2:0] CFG_RAMP_MAX    = 3'd4;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_SET  = 1'b1;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_READ  = 6'b000010,
        ST_MUL   = 6'b000100,
        ST_DIV   = 6'b001000,
        ST_FETCH = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    // The minimum is applied first, so the maximum wins when they cross.
    function automatic logic [11:0] clamp_width(input logic [11:0] w,
                                                input logic [11:0] lo,
                                                input logic [11:0] hi);
        logic [11:0] r;
        r = w;
        if (r < lo) r = lo;
        if (r > hi) r = hi;
        return r;
    endfunction

endpackage

/* rtl/msr_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module msr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                                     aclk,
    input  logic                                     wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                         wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/msr_div.sv */
// Restoring unsigned divider that retires one quotient bit per cycle.
module msr_div #(
    parameter int DIVIDEND_W = 28,
    parameter int DIVISOR_W  = 14
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  busy_reg;
    logic                  done_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  rem_next;
    logic [DIVISOR_W-1:0]  div_reg;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVISOR_W:0]    rem_shift;
    logic [DIVISOR_W:0]    rem_diff;
    logic                  take;

    always_comb begin
        rem_shift = {rem_reg, quo_reg[DIVIDEND_W-1]};
        rem_diff  = rem_shift - {1'b0, div_reg};
        take      = (rem_shift >= {1'b0, div_reg});
        rem_next  = take ? rem_diff[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIVIDEND_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            div_reg <= divisor;
            quo_reg <= dividend;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[DIVIDEND_W-2:0], take};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* rtl/multi_servo_pwm_ramp.sv */
// Top level of the time-multiplexed servo pulse generator with width ramping.
//
// Channel  Dir  Handshake          Payload
// s_       in   s_valid, s_ready   s_cmd, s_channel, s_target_us, s_ramp_ms
// m_       out  m_valid, m_ready   m_pin_levels, m_active_channel, m_pulse_width_us,
//                                  m_high_phase
// cfg_     in   cfg_wr_en          cfg_index, cfg_wdata
//
// A tick item goes from idle to done directly, or via read or fetch when a phase
// event reads the channel memory. A set item goes to done directly for a channel
// that does not exist, via read when it jumps to the target and via read, multiply
// and divide when it ramps; the divider retires one quotient bit per cycle.
// Reset is synchronous; each channel entry reads as its default until first written.
// While a result waits in the output register the next item is accepted and held
// at its final step until the result is taken.
`include "multi_servo_pwm_ramp_assert.svh"

module multi_servo_pwm_ramp
    import msr_pkg::*;
#(
    parameter int NUM_CHANNELS = 4,
    parameter int FRAC_BITS    = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [13:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_cmd,
    input  logic [3:0]  s_channel,
    input  logic [11:0] s_target_us,
    input  logic [13:0] s_ramp_ms,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_pin_levels,
    output logic [1:0]  m_active_channel,
    output logic [11:0] m_pulse_width_us,
    output logic        m_high_phase
);

    localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int CW   = 12 + FRAC_BITS;
    localparam int IW   = CW + 1;
    localparam int SW   = CW + 2;
    localparam int PW   = CW + 8;

    typedef struct packed {
        logic [11:0]   target;
        logic [CW-1:0] cur;
        logic [IW-1:0] inc;
    } entry_t;

    localparam int EW = $bits(entry_t);
    localparam entry_t RESET_ENTRY = '{
        target: WIDTH_RESET_US,
        cur:    {WIDTH_RESET_US, {FRAC_BITS{1'b0}}},
        inc:    '0
    };

    state_t            state_reg;
    logic [11:0]       pulse_min_reg;
    logic [11:0]       pulse_max_reg;
    logic [12:0]       slot_len_reg;
    logic [7:0]        ramp_step_reg;
    logic [13:0]       ramp_max_reg;
    logic [CH_W-1:0]   slot_reg;
    logic              high_reg;
    logic [12:0]       ticks_reg;
    logic [11:0]       slot_cur_int_reg;
    logic [NUM_CHANNELS-1:0] valid_reg;
    logic              m_valid_reg;

    logic              op_set_reg;
    logic [CH_W-1:0]   rd_addr_reg;
    logic [11:0]       in_target_reg;
    logic [13:0]       in_ramp_reg;
    logic [11:0]       aim_reg;
    logic [CW-1:0]     cur_reg;
    logic [CW-1:0]     mag_reg;
    logic              neg_reg;
    logic [3:0]        out_pins_reg;
    logic [1:0]        out_chan_reg;
    logic [11:0]       out_width_reg;
    logic              out_high_reg;

    logic [CH_W-1:0]   slot_next;
    logic              chan_ok;
    logic [CH_W-1:0]   ram_raddr;
    logic [EW-1:0]     ram_rdata;
    logic              ram_we;
    entry_t            rd_entry;
    entry_t            wr_entry;

    logic [CW-1:0]     ramp_aimq;
    logic [SW-1:0]     ramp_diff;
    logic [SW-1:0]     ramp_inc_ext;
    logic [SW-1:0]     ramp_sum;
    logic              ramp_snap;
    logic              ramp_zero;
    logic [CW-1:0]     ramp_cur;
    logic [IW-1:0]     ramp_inc;
    logic [11:0]       ramp_w;
    logic [12:0]       ramp_ticks;

    logic [11:0]       low_w;
    logic [12:0]       low_ticks;

    logic [11:0]       set_aim;
    logic [13:0]       set_time;
    logic              set_now;
    logic [CW-1:0]     set_aimq;
    logic [SW-1:0]     set_diff;
    logic [SW-1:0]     set_mag_full;

    logic              div_start;
    logic              div_done;
    logic [PW-1:0]     div_dividend;
    logic [PW-1:0]     div_quotient;
    logic [IW-1:0]     div_q_ext;
    logic [IW-1:0]     div_inc;

    logic [3:0]        slot_ext;
    logic [3:0]        pins_now;

    assign s_ready = (state_reg == ST_IDLE);
    assign chan_ok = ({1'b0, s_channel} < 5'(NUM_CHANNELS));
    assign slot_next = (slot_reg == CH_W'(NUM_CHANNELS - 1)) ? '0 : slot_reg + CH_W'(1);

    always_comb begin
        if (state_reg == ST_IDLE) begin
            if (s_cmd == CMD_SET) begin
                ram_raddr = s_channel[CH_W-1:0];
            end else if (high_reg) begin
                ram_raddr = slot_next;
            end else begin
                ram_raddr = slot_reg;
            end
        end else begin
            ram_raddr = rd_addr_reg;
        end
    end

    msr_ram #(
        .WIDTH(EW),
        .DEPTH(NUM_CHANNELS)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (rd_addr_reg),
        .wr_data (wr_entry),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign rd_entry = valid_reg[rd_addr_reg] ? entry_t'(ram_rdata) : RESET_ENTRY;

    always_comb begin
        ramp_aimq    = {rd_entry.target, {FRAC_BITS{1'b0}}};
        ramp_diff    = {2'b00, ramp_aimq} - {2'b00, rd_entry.cur};
        ramp_inc_ext = {rd_entry.inc[IW-1], rd_entry.inc};
        ramp_sum     = {2'b00, rd_entry.cur} + ramp_inc_ext;
        ramp_zero    = (rd_entry.inc == '0);
        if (!ramp_inc_ext[SW-1]) begin
            ramp_snap = ($signed(ramp_diff) <= $signed(ramp_inc_ext));
        end else begin
            ramp_snap = ($signed(ramp_diff) >= $signed(ramp_inc_ext));
        end
        if (ramp_zero) begin
            ramp_cur = rd_entry.cur;
            ramp_inc = '0;
        end else if (ramp_snap) begin
            ramp_cur = ramp_aimq;
            ramp_inc = '0;
        end else begin
            ramp_cur = ramp_sum[CW-1:0];
            ramp_inc = rd_entry.inc;
        end
        ramp_w     = clamp_width(ramp_cur[CW-1:FRAC_BITS], pulse_min_reg, pulse_max_reg);
        ramp_ticks = (ramp_w == 12'd0) ? 13'd0 : {1'b0, ramp_w} - 13'd1;
    end

    always_comb begin
        low_w = clamp_width(slot_cur_int_reg, pulse_min_reg, pulse_max_reg);
        if (slot_len_reg > {1'b0, low_w}) begin
            low_ticks = slot_len_reg - {1'b0, low_w} - 13'd1;
        end else begin
            low_ticks = 13'd0;
        end
    end

    always_comb begin
        set_aim      = clamp_width(in_target_reg, pulse_min_reg, pulse_max_reg);
        set_time     = (in_ramp_reg > ramp_max_reg) ? ramp_max_reg : in_ramp_reg;
        set_now      = (set_time == 14'd0) || (set_time < {6'b0, ramp_step_reg});
        set_aimq     = {set_aim, {FRAC_BITS{1'b0}}};
        set_diff     = {2'b00, set_aimq} - {2'b00, rd_entry.cur};
        set_mag_full = set_diff[SW-1] ? ('0 - set_diff) : set_diff;
    end

    assign div_start    = (state_reg == ST_MUL);
    assign div_dividend = {8'b0, mag_reg} * {{CW{1'b0}}, ramp_step_reg};

    msr_div #(
        .DIVIDEND_W(PW),
        .DIVISOR_W (14)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (set_time),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign div_q_ext = {1'b0, div_quotient[CW-1:0]};
    assign div_inc   = neg_reg ? ('0 - div_q_ext) : div_q_ext;

    always_comb begin
        ram_we   = 1'b0;
        wr_entry = rd_entry;
        case (state_reg)
            ST_READ: begin
                if (!op_set_reg) begin
                    ram_we       = 1'b1;
                    wr_entry.cur = ramp_cur;
                    wr_entry.inc = ramp_inc;
                end else if (set_now) begin
                    ram_we          = 1'b1;
                    wr_entry.target = set_aim;
                    wr_entry.cur    = set_aimq;
                    wr_entry.inc    = '0;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    ram_we          = 1'b1;
                    wr_entry.target = aim_reg;
                    wr_entry.cur    = cur_reg;
                    wr_entry.inc    = div_inc;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        slot_ext = 4'(slot_reg);
        for (int i = 0; i < 4; i++) begin
            pins_now[i] = high_reg && (slot_ext == 4'(i));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            pulse_min_reg    <= PULSE_MIN_RESET;
            pulse_max_reg    <= PULSE_MAX_RESET;
            slot_len_reg     <= SLOT_LENGTH_RESET;
            ramp_step_reg    <= RAMP_STEP_RESET;
            ramp_max_reg     <= RAMP_MAX_RESET;
            slot_reg         <= '0;
            high_reg         <= 1'b0;
            ticks_reg        <= '0;
            slot_cur_int_reg <= WIDTH_RESET_US;
            valid_reg        <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_PULSE_MIN:   pulse_min_reg <= cfg_wdata[11:0];
                    CFG_PULSE_MAX:   pulse_max_reg <= cfg_wdata[11:0];
                    CFG_SLOT_LENGTH: slot_len_reg  <= cfg_wdata[12:0];
                    CFG_RAMP_STEP:   ramp_step_reg <= cfg_wdata[7:0];
                    CFG_RAMP_MAX:    ramp_max_reg  <= cfg_wdata;
                    default: begin
                    end
                endcase
            end

            if (ram_we) begin
                valid_reg[rd_addr_reg] <= 1'b1;
            end

            if (state_reg == ST_DONE && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        if (s_cmd == CMD_SET) begin
                            state_reg <= chan_ok ? ST_READ : ST_DONE;
                        end else if (ticks_reg != 13'd0) begin
                            ticks_reg <= ticks_reg - 13'd1;
                            state_reg <= ST_DONE;
                        end else if (!high_reg) begin
                            state_reg <= ST_READ;
                        end else begin
                            high_reg  <= 1'b0;
                            slot_reg  <= slot_next;
                            ticks_reg <= low_ticks;
                            state_reg <= ST_FETCH;
                        end
                    end
                end
                ST_READ: begin
                    if (op_set_reg) begin
                        if (set_now) begin
                            if (rd_addr_reg == slot_reg) begin
                                slot_cur_int_reg <= set_aim;
                            end
                            state_reg <= ST_DONE;
                        end else begin
                            state_reg <= ST_MUL;
                        end
                    end else begin
                        high_reg         <= 1'b1;
                        ticks_reg        <= ramp_ticks;
                        slot_cur_int_reg <= ramp_cur[CW-1:FRAC_BITS];
                        state_reg        <= ST_DONE;
                    end
                end
                ST_MUL: begin
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    if (div_done) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_FETCH: begin
                    slot_cur_int_reg <= rd_entry.cur[CW-1:FRAC_BITS];
                    state_reg        <= ST_DONE;
                end
                ST_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_valid) begin
            op_set_reg    <= (s_cmd == CMD_SET);
            rd_addr_reg   <= ram_raddr;
            in_target_reg <= s_target_us;
            in_ramp_reg   <= s_ramp_ms;
        end
        if (state_reg == ST_READ) begin
            aim_reg <= set_aim;
            cur_reg <= rd_entry.cur;
            mag_reg <= set_mag_full[CW-1:0];
            neg_reg <= set_diff[SW-1];
        end
        if (state_reg == ST_DONE && (!m_valid_reg || m_ready)) begin
            out_pins_reg  <= pins_now;
            out_chan_reg  <= slot_ext[1:0];
            out_width_reg <= low_w;
            out_high_reg  <= high_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_pin_levels     = out_pins_reg;
    assign m_active_channel = out_chan_reg;
    assign m_pulse_width_us = out_width_reg;
    assign m_high_phase     = out_high_reg;

    `MSR_ASSERT_IMPLY(a_div_done_in_div, aclk, aresetn, div_done, state_reg == ST_DIV)
    `MSR_ASSERT_IMPLY(a_write_in_rmw, aclk, aresetn, ram_we, state_reg == ST_READ || state_reg == ST_DIV)
    `MSR_ASSERT_NEXT(a_tick_counts_down, aclk, aresetn, s_valid && s_ready && s_cmd == CMD_TICK && ticks_reg != 13'd0, ticks_reg == $past(ticks_reg) - 13'd1)
    `MSR_ASSERT_NEXT(a_done_posts_result, aclk, aresetn, state_reg == ST_DONE && (!m_valid_reg || m_ready), m_valid_reg && state_reg == ST_IDLE)

endmodule

/* dv/multi_servo_pwm_ramp_test.sv */
// Self-checking testbench for the multi-channel servo pulse generator with ramping.
module multi_servo_pwm_ramp_test;
    import msr_pkg::*;

    localparam int CHANNELS    = 4;
    localparam int FRAC        = 8;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic [3:0]  pins;
        logic [1:0]  chan;
        logic [11:0] width;
        logic        high;
    } servo_out_t;

    class servo_pulse_scoreboard;
        logic [11:0]        pmin, pmax;
        logic [12:0]        slot_len;
        logic [7:0]         step_ms;
        logic [13:0]        ramp_limit;
        logic [1:0]         slot;
        logic               pin_high;
        int                 ticks_left;
        logic [11:0]        target_us [CHANNELS];
        logic [19:0]        width_q [CHANNELS];
        logic signed [20:0] increment_q [CHANNELS];
        servo_out_t         pending_outputs[$];
        int                 mismatches;
        int                 results_seen;

        function new();
            pmin       = PULSE_MIN_RESET;
            pmax       = PULSE_MAX_RESET;
            slot_len   = SLOT_LENGTH_RESET;
            step_ms    = RAMP_STEP_RESET;
            ramp_limit = RAMP_MAX_RESET;
            slot       = 2'd0;
            pin_high   = 1'b0;
            ticks_left = 0;
            for (int i = 0; i < CHANNELS; i++) begin
                target_us[i]   = WIDTH_RESET_US;
                width_q[i]     = {WIDTH_RESET_US, 8'h00};
                increment_q[i] = '0;
            end
            mismatches   = 0;
            results_seen = 0;
        endfunction

        function void set_register(logic [2:0] idx, logic [13:0] data);
            case (idx)
                CFG_PULSE_MIN:   pmin = data[11:0];
                CFG_PULSE_MAX:   pmax = data[11:0];
                CFG_SLOT_LENGTH: slot_len = data[12:0];
                CFG_RAMP_STEP:   step_ms = data[7:0];
                CFG_RAMP_MAX:    ramp_limit = data;
                default: ;
            endcase
        endfunction

        function logic [11:0] limit_width(logic [11:0] w);
            logic [11:0] r;
            r = w;
            if (r < pmin) r = pmin;
            if (r > pmax) r = pmax;
            return r;
        endfunction

        function int shown_width(logic [1:0] ch);
            return int'(limit_width(width_q[ch][19:FRAC]));
        endfunction

        function void step_toward_target(logic [1:0] ch);
            longint aim, now, inc;
            bit     snap;
            inc = longint'(increment_q[ch]);
            aim = longint'(target_us[ch]) * (longint'(1) << FRAC);
            now = longint'(width_q[ch]);
            if (inc == 0) return;
            if (inc > 0) snap = (aim - now) <= inc;
            else snap = (now - aim) <= -inc;
            if (snap) begin
                width_q[ch]     = aim[19:0];
                increment_q[ch] = '0;
            end else begin
                now         = now + inc;
                width_q[ch] = now[19:0];
            end
        endfunction

        function void advance_tick();
            int w, len;
            if (ticks_left == 0) begin
                if (!pin_high) begin
                    step_toward_target(slot);
                    w        = shown_width(slot);
                    len      = (w == 0) ? 1 : w;
                    pin_high = 1'b1;
                end else begin
                    w        = shown_width(slot);
                    len      = (int'(slot_len) > w) ? int'(slot_len) - w : 1;
                    pin_high = 1'b0;
                    slot     = slot + 2'd1;
                end
                ticks_left = len;
            end
            ticks_left = ticks_left - 1;
        endfunction

        function void load_target(logic [3:0] ch, logic [11:0] tgt, logic [13:0] ramp);
            logic [11:0] aim;
            logic [13:0] span;
            longint      aim_q, diff, mag;
            if (int'(ch) >= CHANNELS) return;
            aim  = limit_width(tgt);
            span = (ramp > ramp_limit) ? ramp_limit : ramp;
            target_us[ch[1:0]] = aim;
            aim_q = longint'(aim) * (longint'(1) << FRAC);
            if (span == 0 || span < step_ms) begin
                width_q[ch[1:0]]     = aim_q[19:0];
                increment_q[ch[1:0]] = '0;
                return;
            end
            diff = aim_q - longint'(width_q[ch[1:0]]);
            mag  = (diff < 0) ? -diff : diff;
            mag  = mag * longint'(step_ms) / longint'(span);
            if (diff < 0) mag = -mag;
            increment_q[ch[1:0]] = mag[20:0];
        endfunction

        function void note_item(logic cmd, logic [3:0] ch, logic [11:0] tgt,
                                logic [13:0] ramp);
            servo_out_t e;
            if (cmd == CMD_TICK) advance_tick();
            else load_target(ch, tgt, ramp);
            e.pins       = 4'b0000;
            e.pins[slot] = pin_high;
            e.chan       = slot;
            e.width      = limit_width(width_q[slot][19:FRAC]);
            e.high       = pin_high;
            pending_outputs.push_back(e);
        endfunction

        task report(string msg);
            mismatches++;
            $display("ERROR: %s", msg);
        endtask

        task check_output(servo_out_t got);
            servo_out_t e;
            results_seen++;
            if (pending_outputs.size() == 0) begin
                report($sformatf("result %0d arrived with nothing expected", results_seen));
                return;
            end
            e = pending_outputs.pop_front();
            if (got.pins !== e.pins)
                report($sformatf("result %0d: pin levels %h, expected %h",
                                 results_seen, got.pins, e.pins));
            if (got.chan !== e.chan)
                report($sformatf("result %0d: active channel %0d, expected %0d",
                                 results_seen, got.chan, e.chan));
            if (got.width !== e.width)
                report($sformatf("result %0d: pulse width %0d, expected %0d",
                                 results_seen, got.width, e.width));
            if (got.high !== e.high)
                report($sformatf("result %0d: high phase %b, expected %b",
                                 results_seen, got.high, e.high));
        endtask
    endclass

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [2:0]  cfg_index;
    logic [13:0] cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    logic        s_cmd;
    logic [3:0]  s_channel;
    logic [11:0] s_target_us;
    logic [13:0] s_ramp_ms;
    logic        m_valid;
    logic        m_ready;
    logic [3:0]  m_pin_levels;
    logic [1:0]  m_active_channel;
    logic [11:0] m_pulse_width_us;
    logic        m_high_phase;

    servo_pulse_scoreboard sb;
    int send_idle;
    int recv_idle;
    int cycles;

    multi_servo_pwm_ramp u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_cmd            (s_cmd),
        .s_channel        (s_channel),
        .s_target_us      (s_target_us),
        .s_ramp_ms        (s_ramp_ms),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_pin_levels     (m_pin_levels),
        .m_active_channel (m_active_channel),
        .m_pulse_width_us (m_pulse_width_us),
        .m_high_phase     (m_high_phase)
    );

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99, 0) >= recv_idle);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_output({m_pin_levels, m_active_channel, m_pulse_width_us, m_high_phase});
        end
    end

    always @(posedge aclk) begin
        cycles = cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("multi_servo_pwm_ramp_test: FAIL");
            $finish;
        end
    end

    task automatic send_item(input logic cmd, input logic [3:0] ch,
                             input logic [11:0] tgt, input logic [13:0] ramp);
        while ($urandom_range(99, 0) < send_idle) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_cmd       <= cmd;
        s_channel   <= ch;
        s_target_us <= tgt;
        s_ramp_ms   <= ramp;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_item(cmd, ch, tgt, ramp);
        @(negedge aclk);
    endtask

    task automatic wait_for_outputs();
        s_valid <= 1'b0;
        do @(negedge aclk); while (sb.pending_outputs.size() != 0);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [13:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        sb.set_register(idx, data);
        @(negedge aclk);
    endtask

    task automatic write_settings(input logic [11:0] lo, input logic [11:0] hi,
                                  input logic [12:0] slot, input logic [7:0] step,
                                  input logic [13:0] rmax);
        write_reg(CFG_PULSE_MIN, 14'(lo));
        write_reg(CFG_PULSE_MAX, 14'(hi));
        write_reg(CFG_SLOT_LENGTH, 14'(slot));
        write_reg(CFG_RAMP_STEP, 14'(step));
        write_reg(CFG_RAMP_MAX, rmax);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic random_item();
        int lo, hi, s, tgt, ramp;
        logic [3:0] ch;
        lo = (sb.pmin < sb.pmax) ? int'(sb.pmin) : int'(sb.pmax);
        hi = (sb.pmin < sb.pmax) ? int'(sb.pmax) : int'(sb.pmin);
        s  = int'(sb.step_ms);
        if ($urandom_range(99, 0) < 78) begin
            send_item(CMD_TICK, 4'($urandom_range(15, 0)), 12'($urandom_range(4095, 0)),
                      14'($urandom_range(16383, 0)));
            return;
        end
        ch = ($urandom_range(9, 0) == 0) ? 4'($urandom_range(15, 0))
                                          : 4'($urandom_range(3, 0));
        if ($urandom_range(7, 0) == 0) tgt = $urandom_range(4095, 0);
        else tgt = $urandom_range((hi + 3 > 4095) ? 4095 : hi + 3, (lo > 3) ? lo - 3 : 0);
        case ($urandom_range(5, 0))
            0: ramp = 0;
            1: ramp = $urandom_range(s, 0);
            2, 3: ramp = $urandom_range((s * 8 > 16383) ? 16383 : s * 8, s);
            4: ramp = $urandom_range(16383, 0);
            default: ramp = int'(sb.ramp_limit);
        endcase
        send_item(CMD_SET, ch, 12'(tgt), 14'(ramp));
    endtask

    task automatic run_phase(input logic [11:0] lo, input logic [11:0] hi,
                             input logic [12:0] slot, input logic [7:0] step,
                             input logic [13:0] rmax, input int count);
        wait_for_outputs();
        write_settings(lo, hi, slot, step, rmax);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(249, 0) == 0) wait_for_outputs();
            random_item();
        end
    endtask

    initial begin
        sb          = new();
        cycles      = 0;
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_index   = CFG_PULSE_MIN;
        cfg_wdata   = '0;
        s_valid     = 1'b0;
        s_cmd       = CMD_TICK;
        s_channel   = '0;
        s_target_us = '0;
        s_ramp_ms   = '0;
        send_idle   = 28;
        recv_idle   = 75;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset settings: saturated ramp, ignored channels, jumps, ramp at the step period.
        send_item(CMD_SET, 4'd0, 12'd4095, 14'd16383);
        send_item(CMD_SET, 4'd15, 12'd0, 14'd0);
        send_item(CMD_SET, 4'd4, 12'd1, 14'd1);
        send_item(CMD_SET, 4'd1, 12'd0, 14'd0);
        send_item(CMD_SET, 4'd2, 12'd2000, 14'd19);
        send_item(CMD_SET, 4'd3, 12'd1000, 14'd20);
        send_item(CMD_SET, 4'd0, 12'd100, 14'd10000);
        wait_for_outputs();

        // Widest settings: zero pulse width, pulse longer than the slot, longest ramp.
        write_settings(12'd0, 12'd4095, 13'd1, 8'd1, 14'd16383);
        send_item(CMD_SET, 4'd0, 12'd0, 14'd0);
        send_item(CMD_SET, 4'd1, 12'd5, 14'd0);
        send_item(CMD_SET, 4'd2, 12'd0, 14'd1);
        send_item(CMD_SET, 4'd3, 12'd4095, 14'd16383);
        send_item(CMD_SET, 4'd3, 12'd4, 14'd0);
        send_item(CMD_SET, 4'd15, 12'd100, 14'd0);
        repeat (12) send_item(CMD_TICK, 4'd0, 12'd0, 14'd0);

        run_phase(12'd0, 12'd10, 13'd12, 8'd4, 14'd200, 300);
        run_phase(12'd2, 12'd8, 13'd6, 8'd1, 14'd40, 250);
        send_idle = 75;
        recv_idle = 28;
        run_phase(12'd20, 12'd5, 13'd14, 8'd2, 14'd60, 200);
        run_phase(12'd0, 12'd30, 13'd40, 8'd8, 14'd16383, 200);
        send_idle = 0;
        recv_idle = 0;
        run_phase(12'd1, 12'd12, 13'd16, 8'd3, 14'd0, 150);
        run_phase(12'd0, 12'd4095, 13'd1, 8'd255, 14'd16383, 150);
        run_phase(12'd4095, 12'd4095, 13'd8191, 8'd1, 14'd100, 100);

        wait_for_outputs();
        repeat (40) @(posedge aclk);
        if (sb.mismatches == 0) begin
            $display("multi_servo_pwm_ramp_test: PASS");
        end else begin
            $display("multi_servo_pwm_ramp_test: FAIL");
        end
        $finish;
    end

endmodule
